### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/mlpq_pkg.sv
// Types, codes and defaults shared by the multilevel priority FIFO files.
package mlpq_pkg;

   // Default sizing
   localparam int LEVELS_DEF   = 8;
   localparam int DEPTH_DEF    = 16;
   localparam int ID_WIDTH_DEF = 8;

   // Fixed field widths of the item ports
   localparam int ID_FIELD_W  = 8;
   localparam int LVL_FIELD_W = 3;
   localparam int CSR_W       = 4;

   // Reset value of the levels-in-use register
   localparam logic [CSR_W-1:0] LEVELS_IN_USE_RESET = 4'd8;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  op;
      logic [ID_FIELD_W-1:0]   requester_id;
      logic [LVL_FIELD_W-1:0]  priority_level;
   } req_type;

   typedef struct packed {
      logic [ID_FIELD_W-1:0]   popped_id;
      logic [LVL_FIELD_W-1:0]  popped_level;
      status_type              status;
   } rsp_type;

   // Memory command from the controller to the entry store
   typedef struct packed {
      logic wr;
      logic rd;
   } mem_ctl_type;

endpackage

### design/mlpq_store.sv
// Entry store: one synchronous RAM holding every level's ring buffer.
module mlpq_store
   import mlpq_pkg::*;
#(
   parameter int LEVELS   = LEVELS_DEF,
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF,
   localparam int ENTRIES = LEVELS * DEPTH,
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  mem_ctl_type         mem_ctl,
   input  logic [ADDR_W-1:0]   mem_addr,
   input  logic [ID_WIDTH-1:0] mem_wdata,
   output logic [ID_WIDTH-1:0] mem_rdata
);

   logic [ID_WIDTH-1:0] mem_array [ENTRIES];
   logic [ID_WIDTH-1:0] rd_data_ff;

   // Write on push
   always_ff @(posedge clock) begin
      if (mem_ctl.wr) begin
         mem_array[mem_addr] <= mem_wdata;
      end
   end

   // Read on pop, data registered into rd_data_ff
   always_ff @(posedge clock) begin
      if (mem_ctl.rd) begin
         rd_data_ff <= mem_array[mem_addr];
      end
   end

   assign mem_rdata = rd_data_ff;

endmodule

### design/mlpq_ctrl.sv
// Controller: levels register, per-level pointers and counts, level search.
module mlpq_ctrl
   import mlpq_pkg::*;
#(
   parameter int LEVELS   = LEVELS_DEF,
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF,
   localparam int ENTRIES = LEVELS * DEPTH,
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  req_type                req,
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_wdata,
   output mem_ctl_type            mem_ctl,
   output logic [ADDR_W-1:0]      mem_addr,
   output logic [ID_WIDTH-1:0]    mem_wdata,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [LVL_FIELD_W-1:0] rsp_level,
   output status_type             rsp_status
);

   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [CSR_W-1:0]       levels_ff;
   logic [PTR_W-1:0]       head_ff  [LEVELS];
   logic [PTR_W-1:0]       tail_ff  [LEVELS];
   logic [CNT_W-1:0]       count_ff [LEVELS];
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [LVL_FIELD_W-1:0] rsp_level_ff;
   status_type             rsp_status_ff;

   logic [LEVELS-1:0]   ready_lvl;
   logic                hit;
   logic [LVL_W-1:0]    hit_idx;
   logic [LVL_W-1:0]    push_idx;
   logic [ID_WIDTH-1:0] push_id;
   logic                push_range;
   logic                push_full;
   logic                do_push;
   logic                do_pop;
   status_type          status_in;

   // Levels register, written only while idle: a rule for the user, unchecked by the block
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_IN_USE_RESET;
      end else if (csr_we) begin
         levels_ff <= csr_wdata;
      end
   end

   // Mark levels that are in use and hold entries
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         ready_lvl[i] = (int'(levels_ff) > i) && (count_ff[i] != '0);
      end
   end

   // Find the lowest-numbered ready level
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (ready_lvl[i]) begin
            hit     = 1'b1;
            hit_idx = LVL_W'(i);
         end
      end
   end

   // Decode the item
   always_comb begin
      push_idx   = LVL_W'(req.priority_level);
      push_id    = ID_WIDTH'(req.requester_id);
      push_range = (int'(req.priority_level) >= LEVELS) ||
                   (int'(req.priority_level) >= int'(levels_ff));
      push_full  = (count_ff[push_idx] == CNT_FULL);
      do_push    = 1'b0;
      do_pop     = 1'b0;
      status_in  = ST_OK;
      if (req.op == OP_PUSH) begin
         if (push_range) begin
            status_in = ST_RANGE;
         end else if (push_full) begin
            status_in = ST_FULL;
         end else begin
            do_push = accept && (push_id != '0);
         end
      end else begin
         if (hit) begin
            do_pop = accept;
         end else begin
            status_in = ST_EMPTY;
         end
      end
   end

   // Drive the RAM port: tail slot on push, head slot on pop
   always_comb begin
      mem_ctl.wr = do_push;
      mem_ctl.rd = do_pop;
      mem_wdata  = push_id;
      if (req.op == OP_PUSH) begin
         mem_addr = ADDR_W'(ADDR_W'(push_idx) * ADDR_W'(DEPTH) + ADDR_W'(tail_ff[push_idx]));
      end else begin
         mem_addr = ADDR_W'(ADDR_W'(hit_idx) * ADDR_W'(DEPTH) + ADDR_W'(head_ff[hit_idx]));
      end
   end

   // Advance pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (do_push) begin
            tail_ff[push_idx]  <= (tail_ff[push_idx] == PTR_LAST) ? '0
                                  : tail_ff[push_idx] + 1'b1;
            count_ff[push_idx] <= count_ff[push_idx] + 1'b1;
         end
         if (do_pop) begin
            head_ff[hit_idx]  <= (head_ff[hit_idx] == PTR_LAST) ? '0
                                 : head_ff[hit_idx] + 1'b1;
            count_ff[hit_idx] <= count_ff[hit_idx] - 1'b1;
         end
      end
   end

   // Strobe the result in the cycle after accept
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // Hold result details for the output cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff    <= do_pop;
         rsp_level_ff  <= do_pop ? LVL_FIELD_W'(hit_idx) : '0;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_level  = rsp_level_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### design/multilevel_priority_fifo.sv
// Top level of the multilevel priority FIFO: controller, entry store, result port.
//
// A priority queue of LEVELS ring buffers, DEPTH ids each, held in one
// single-port synchronous RAM. busy is never raised: an item is taken every
// clock, and its result strobes on rsp_valid in the cycle after accept,
// because a pop reads its id from the RAM, whose read data is registered.
// Results cannot be held off, so sample them on the strobe.
// Pointers and counts clear at reset; RAM contents are never cleared since
// only counted entries are read. Write csr_wdata (levels in use) only while
// no item is in flight.
module multilevel_priority_fifo
   import mlpq_pkg::*;
#(
   parameter int LEVELS   = LEVELS_DEF,
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int ENTRIES = LEVELS * DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   mem_ctl_type            mem_ctl;
   logic [ADDR_W-1:0]      mem_addr;
   logic [ID_WIDTH-1:0]    mem_wdata;
   logic [ID_WIDTH-1:0]    mem_rdata;
   logic                   accept;
   logic                   rsp_hit;
   logic [LVL_FIELD_W-1:0] rsp_level;
   status_type             rsp_status;

   // Take an item on every start
   assign busy   = 1'b0;
   assign accept = start && !busy;

   mlpq_ctrl #(
      .LEVELS   (LEVELS),
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_hit    (rsp_hit),
      .rsp_level  (rsp_level),
      .rsp_status (rsp_status)
   );

   mlpq_store #(
      .LEVELS   (LEVELS),
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // Assemble the result, zero id unless a pop hit
   always_comb begin
      rsp_data.popped_id    = rsp_hit ? ID_FIELD_W'(mem_rdata) : '0;
      rsp_data.popped_level = rsp_level;
      rsp_data.status       = rsp_status;
   end

endmodule

### design/mlpq_checker.sv
// Port-level checker for the multilevel priority FIFO, bound to the top level.
`include "assert_macros.svh"

module mlpq_checker
   import mlpq_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input req_type          req_data,
   input logic             rsp_valid,
   input rsp_type          rsp_data,
   input logic             csr_we,
   input logic [CSR_W-1:0] csr_wdata
);

   logic accepted;
   logic csr_seen;

   assign accepted = start && !busy;
   assign csr_seen = csr_we && (csr_wdata != '0 || csr_wdata == '0);

   // Every accepted item gets its result in the next cycle
   `ASSERT_NEXT(a_result_follows, clock, reset, accepted, rsp_valid)

   // No result without an item accepted the cycle before
   `ASSERT_IMPLIES(a_no_stray_result, clock, reset, rsp_valid && !$past(reset), $past(accepted))

   // Failed items carry no id and no level
   `ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.popped_id == '0 && rsp_data.popped_level == '0)

   // A push never returns an id
   `ASSERT_IMPLIES(a_push_no_id, clock, reset, rsp_valid && !$past(reset) && $past(req_data.op) == OP_PUSH, rsp_data.popped_id == '0)

   // Push results never report an empty queue
   `ASSERT_IMPLIES(a_push_not_empty, clock, reset, rsp_valid && !$past(reset) && $past(req_data.op) == OP_PUSH && !$past(csr_seen), rsp_data.status != ST_EMPTY)

endmodule

bind multilevel_priority_fifo mlpq_checker u_mlpq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);

### tb/sv/tb_multilevel_priority_fifo.sv
// Self-checking testbench for the multilevel priority FIFO: random pushes and pops against a predictor.
module tb_multilevel_priority_fifo;
   import mlpq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LEVELS = LEVELS_DEF;
   localparam int FIFO_DEPTH = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CSR_W-1:0] csr_wdata = LEVELS_IN_USE_RESET;

   // Predictor state: per-level ring buffers and the levels-in-use register
   logic [ID_FIELD_W-1:0] level_ring [NUM_LEVELS][FIFO_DEPTH];
   int unsigned           ring_head [NUM_LEVELS];
   int unsigned           ring_tail [NUM_LEVELS];
   int unsigned           ring_fill [NUM_LEVELS];
   logic [CSR_W-1:0]      levels_reg = LEVELS_IN_USE_RESET;

   req_type     pending_items [$];
   rsp_type     expected_results [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Sender pacing
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned gap_pct = 30;
   int unsigned hot_level = 0;

   multilevel_priority_fifo i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one push or pop to the predictor and return the result it should give
   function automatic rsp_type apply_queue_op(req_type item);
      rsp_type     res;
      int unsigned active;
      int unsigned lvl;
      res.popped_id = '0;
      res.popped_level = '0;
      res.status = ST_OK;
      active = (int'(levels_reg) > NUM_LEVELS) ? NUM_LEVELS : int'(levels_reg);
      if (item.op == OP_PUSH) begin
         lvl = int'(item.priority_level);
         if (lvl >= active) begin
            res.status = ST_RANGE;
         end else if (ring_fill[lvl] >= FIFO_DEPTH) begin
            res.status = ST_FULL;
         end else if (item.requester_id != '0) begin
            level_ring[lvl][ring_tail[lvl]] = item.requester_id;
            ring_tail[lvl] = (ring_tail[lvl] + 1) % FIFO_DEPTH;
            ring_fill[lvl]++;
         end
      end else begin
         res.status = ST_EMPTY;
         for (int i = 0; i < active && res.status == ST_EMPTY; i++) begin
            if (ring_fill[i] != 0) begin
               res.popped_id = level_ring[i][ring_head[i]];
               res.popped_level = LVL_FIELD_W'(i);
               res.status = ST_OK;
               ring_head[i] = (ring_head[i] + 1) % FIFO_DEPTH;
               ring_fill[i]--;
            end
         end
      end
      return res;
   endfunction

   // Build one random item; pushes favor a hot level so levels fill up
   function automatic req_type make_item(int unsigned active, int unsigned push_pct);
      req_type item;
      item.op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      item.requester_id = ID_FIELD_W'($urandom_range(1, 255));
      item.priority_level = LVL_FIELD_W'($urandom_range(0, 7));
      if (item.op == OP_PUSH) begin
         if (active != 0 && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 1) == 0 && hot_level < active) begin
               item.priority_level = LVL_FIELD_W'(hot_level);
            end else begin
               item.priority_level = LVL_FIELD_W'($urandom_range(0, active - 1));
            end
         end
         if ($urandom_range(0, 24) == 0) begin
            item.requester_id = '0;
         end
      end
      return item;
   endfunction

   function automatic req_type mk(op_type op, int unsigned id, int unsigned lvl);
      req_type item;
      item.op = op;
      item.requester_id = ID_FIELD_W'(id);
      item.priority_level = LVL_FIELD_W'(lvl);
      return item;
   endfunction

   // Hold until every item is sent and every result is back, then let the pipe settle
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || start || expected_results.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_levels(logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      levels_reg = value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Fill-then-drain phase of random items
   task automatic queue_random_phase(int unsigned count);
      int unsigned active;
      active = (int'(levels_reg) > NUM_LEVELS) ? NUM_LEVELS : int'(levels_reg);
      hot_level = $urandom_range(0, NUM_LEVELS - 1);
      for (int unsigned n = 0; n < count; n++) begin
         pending_items.push_back(make_item(active, (n < count / 2) ? 75 : 30));
      end
   endtask

   // Driver: predict accepted items, then present the next one unless pausing
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_results.push_back(apply_queue_op(req_data));
         end
         if (gap_left != 0 || pending_items.size() == 0) begin
            start <= 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end
         end else begin
            start <= 1'b1;
            req_data <= pending_items.pop_front();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Monitor: check each strobed result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: id %0d level %0d status %0d",
                   rsp_data.popped_id, rsp_data.popped_level, rsp_data.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.popped_id !== want.popped_id) begin
               $error("popped_id: expected %0d, got %0d", want.popped_id, rsp_data.popped_id);
               error_count++;
            end
            if (rsp_data.popped_level !== want.popped_level) begin
               $error("popped_level: expected %0d, got %0d",
                      want.popped_level, rsp_data.popped_level);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [CSR_W-1:0] level_settings [10];
      level_settings = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd8, 4'd5, 4'd9, 4'd3, 4'd0, 4'd0};
      level_settings[8] = CSR_W'($urandom_range(0, 15));
      level_settings[9] = CSR_W'($urandom_range(0, 15));
      for (int i = 0; i < NUM_LEVELS; i++) begin
         ring_head[i] = 0;
         ring_tail[i] = 0;
         ring_fill[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty pop, id extremes, zero id, arrival order within a level
      pending_items.push_back(mk(OP_POP, 8'hFF, 7));
      pending_items.push_back(mk(OP_PUSH, 255, 7));
      pending_items.push_back(mk(OP_PUSH, 1, 0));
      pending_items.push_back(mk(OP_PUSH, 0, 3));
      pending_items.push_back(mk(OP_PUSH, 8'hAA, 0));
      pending_items.push_back(mk(OP_PUSH, 8'h55, 7));
      pending_items.push_back(mk(OP_POP, 8'hFF, 7));
      pending_items.push_back(mk(OP_POP, 0, 0));
      pending_items.push_back(mk(OP_POP, 8'h12, 5));
      pending_items.push_back(mk(OP_POP, 8'h34, 2));
      pending_items.push_back(mk(OP_POP, 8'h56, 1));
      wait_drained();

      // Directed under one level: range error above it, then fill level 0 past full
      write_levels(4'd1);
      pending_items.push_back(mk(OP_PUSH, 8'h80, 1));
      pending_items.push_back(mk(OP_PUSH, 8'h7F, 7));
      for (int n = 0; n < FIFO_DEPTH + 1; n++) begin
         pending_items.push_back(mk(OP_PUSH, n + 1, 0));
      end
      wait_drained();

      // Random at the reset value, leaving entries behind for later phases
      write_levels(4'd8);
      queue_random_phase(150);
      wait_drained();

      // Random phases across settings, some with no sender gaps
      for (int p = 0; p < 10; p++) begin
         gap_pct = (p % 3 == 1) ? 0 : 30;
         write_levels(level_settings[p]);
         queue_random_phase(175);
         wait_drained();
      end

      repeat (5) @(negedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/mlpq_pkg.sv
design/mlpq_store.sv
design/mlpq_ctrl.sv
design/multilevel_priority_fifo.sv
design/mlpq_checker.sv
tb/sv/tb_multilevel_priority_fifo.sv
